/* rtl/tve_pkg.sv */
// ----------------------------------------------------------------------------
// tve_pkg: shared types and tables for the voxel edge emitter
// Tetrahedron corner loop, 16-case triangle count and edge tables, and the
// voxel descriptor that travels from the classifier to the vertex sequencer.
// ----------------------------------------------------------------------------
package tve_pkg;

   localparam int TETS = 6;

   // Fixed cube corners shared by every tetrahedron
   localparam logic [2:0] CORNER_ORIGIN = 3'd0;
   localparam logic [2:0] CORNER_FAR    = 3'd7;

   // Tetrahedron-local corner numbers
   localparam logic [1:0] TC_ORIGIN = 2'd0;
   localparam logic [1:0] TC_FAR    = 2'd1;
   localparam logic [1:0] TC_LOOP_A = 2'd2;
   localparam logic [1:0] TC_LOOP_B = 2'd3;

   // Last vertex slot of a tet with one or with two triangles
   localparam logic [2:0] SLOT_END_ONE = 3'd2;
   localparam logic [2:0] SLOT_END_TWO = 3'd5;

   typedef logic [3:0] case_idx_type;
   typedef logic [2:0] corner_type;

   typedef struct packed {
      case_idx_type [TETS-1:0] cases;
      logic [TETS-1:0]         nonempty;
      logic [31:0]             x_lo;
      logic [31:0]             x_hi;
      logic [31:0]             y_lo;
      logic [31:0]             y_hi;
      logic [31:0]             z_lo;
      logic [31:0]             z_hi;
   } voxel_desc_type;

   // Corner loop 6,4,5,1,3,2,6 around the main diagonal
   function automatic corner_type loop_corner(input logic [2:0] idx);
      corner_type c;
      unique case (idx)
         3'd0:    c = 3'd6;
         3'd1:    c = 3'd4;
         3'd2:    c = 3'd5;
         3'd3:    c = 3'd1;
         3'd4:    c = 3'd3;
         3'd5:    c = 3'd2;
         default: c = 3'd6;
      endcase
      return c;
   endfunction

   // Map a tetrahedron-local corner to its cube corner
   function automatic corner_type tet_corner(input logic [2:0] tet, input logic [1:0] k);
      corner_type c;
      unique case (k)
         TC_ORIGIN: c = CORNER_ORIGIN;
         TC_FAR:    c = CORNER_FAR;
         TC_LOOP_A: c = loop_corner(tet);
         default:   c = loop_corner(tet + 3'd1);
      endcase
      return c;
   endfunction

   // Triangles produced by a tetrahedron sign case
   function automatic logic [1:0] tri_count(input case_idx_type cs);
      logic [1:0] n;
      unique case (cs) inside
         4'd0, 4'd15:                         n = 2'd0;
         4'd1, 4'd2, 4'd4, 4'd7, 4'd8,
         4'd11, 4'd13, 4'd14:                 n = 2'd1;
         default:                             n = 2'd2;
      endcase
      return n;
   endfunction

   // Edge table row: slot s in bits [4s+3:4s] as {start corner, end corner}
   function automatic logic [23:0] edge_row(input case_idx_type cs);
      logic [23:0] r;
      unique case (cs)
         4'd1:    r = 24'h000312;
         4'd2:    r = 24'h000476;
         4'd3:    r = 24'h623376;
         4'd4:    r = 24'h0009B8;
         4'd5:    r = 24'h3199B3;
         4'd6:    r = 24'h47B4B8;
         4'd7:    r = 24'h00037B;
         4'd8:    r = 24'h000EDC;
         4'd9:    r = 24'h1ED12E;
         4'd10:   r = 24'h64CCE6;
         4'd11:   r = 24'h0002E6;
         4'd12:   r = 24'hC899DC;
         4'd13:   r = 24'h00019D;
         4'd14:   r = 24'h00084C;
         default: r = 24'h000000;
      endcase
      return r;
   endfunction

endpackage

/* rtl/tve_front.sv */
// ----------------------------------------------------------------------------
// tve_front: voxel intake and classification
// Forms the six tetrahedron sign cases of each voxel, drops uniform voxels
// and holds one descriptor for the queue.
// ----------------------------------------------------------------------------
module tve_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              corner_negative,
   input  logic [31:0]             x_lo,
   input  logic [31:0]             x_hi,
   input  logic [31:0]             y_lo,
   input  logic [31:0]             y_hi,
   input  logic [31:0]             z_lo,
   input  logic [31:0]             z_hi,
   output logic                    push_valid,
   input  logic                    push_ready,
   output tve_pkg::voxel_desc_type push_desc
);

   logic                    valid_ff, valid_in;
   tve_pkg::voxel_desc_type desc_ff, desc_in;
   logic                    accept;

   // Classify each tetrahedron from its four corner signs
   always_comb begin
      desc_in      = '0;
      desc_in.x_lo = x_lo;
      desc_in.x_hi = x_hi;
      desc_in.y_lo = y_lo;
      desc_in.y_hi = y_hi;
      desc_in.z_lo = z_lo;
      desc_in.z_hi = z_hi;
      for (int t = 0; t < tve_pkg::TETS; t++) begin
         for (int k = 0; k < 4; k++) begin
            desc_in.cases[t][k] = corner_negative[tve_pkg::tet_corner(3'(t), 2'(k))];
         end
         desc_in.nonempty[t] = (tve_pkg::tri_count(desc_in.cases[t]) != 2'd0);
      end
   end

   assign req_ready = !valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   // Hold a descriptor until the queue takes it; drop voxels with no vertex
   always_comb begin
      if (accept) begin
         valid_in = |desc_in.nonempty;
      end else begin
         valid_in = valid_ff && !push_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_desc  = desc_ff;

endmodule

/* rtl/tve_queue.sv */
// ----------------------------------------------------------------------------
// tve_queue: descriptor queue
// Small first-in first-out buffer that decouples classification from
// vertex emission.
// ----------------------------------------------------------------------------
module tve_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  tve_pkg::voxel_desc_type push_desc,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output tve_pkg::voxel_desc_type pop_desc
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   tve_pkg::voxel_desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_desc   = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming descriptor
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

/* rtl/tve_back.sv */
// ----------------------------------------------------------------------------
// tve_back: vertex sequencer
// Walks the non-empty tetrahedra of the head descriptor and emits one edge
// vertex per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module tve_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  tve_pkg::voxel_desc_type pop_desc,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              tet_number,
   output logic [2:0]              vertex_slot,
   output logic [2:0]              corner_first,
   output logic [2:0]              corner_second,
   output logic [31:0]             first_x,
   output logic [31:0]             first_y,
   output logic [31:0]             first_z,
   output logic [31:0]             second_x,
   output logic [31:0]             second_y,
   output logic [31:0]             second_z,
   output logic                    last_of_voxel
);

   logic [2:0]                tet_ff, tet_in;
   logic [2:0]                slot_ff, slot_in;
   logic                      valid_ff, valid_in;
   logic [2:0]                cur_tet;
   logic                      later_any;
   tve_pkg::case_idx_type     cur_case;
   logic [23:0]               row;
   logic [3:0]                ends;
   tve_pkg::corner_type       corner_a, corner_b;
   logic [2:0]                slot_end;
   logic                      tet_done, voxel_done;
   logic                      emit;

   // Find the first non-empty tet at or after the cursor
   always_comb begin
      cur_tet   = '0;
      later_any = 1'b0;
      for (int t = tve_pkg::TETS - 1; t >= 0; t--) begin
         if (pop_desc.nonempty[t] && (3'(t) >= tet_ff)) begin
            cur_tet = 3'(t);
         end
      end
      for (int t = 0; t < tve_pkg::TETS; t++) begin
         if (pop_desc.nonempty[t] && (3'(t) > cur_tet)) begin
            later_any = 1'b1;
         end
      end
   end

   // Look up the crossed edge of the current vertex
   always_comb begin
      cur_case   = pop_desc.cases[cur_tet];
      row        = tve_pkg::edge_row(cur_case);
      ends       = row[slot_ff*4 +: 4];
      corner_a   = tve_pkg::tet_corner(cur_tet, ends[3:2]);
      corner_b   = tve_pkg::tet_corner(cur_tet, ends[1:0]);
      slot_end   = (tve_pkg::tri_count(cur_case) == 2'd2) ?
                   tve_pkg::SLOT_END_TWO : tve_pkg::SLOT_END_ONE;
      tet_done   = (slot_ff == slot_end);
      voxel_done = tet_done && !later_any;
   end

   assign emit      = pop_valid && (!valid_ff || rsp_ready);
   assign pop_ready = emit && voxel_done;

   // Advance the vertex cursor
   always_comb begin
      tet_in  = tet_ff;
      slot_in = slot_ff;
      if (emit) begin
         if (voxel_done) begin
            tet_in  = '0;
            slot_in = '0;
         end else if (tet_done) begin
            tet_in  = cur_tet + 3'd1;
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 3'd1;
         end
      end
      if (emit) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tet_ff   <= '0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         tet_ff   <= tet_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         tet_number    <= cur_tet;
         vertex_slot   <= slot_ff;
         corner_first  <= corner_a;
         corner_second <= corner_b;
         first_x       <= corner_a[2] ? pop_desc.x_hi : pop_desc.x_lo;
         first_y       <= corner_a[1] ? pop_desc.y_hi : pop_desc.y_lo;
         first_z       <= corner_a[0] ? pop_desc.z_hi : pop_desc.z_lo;
         second_x      <= corner_b[2] ? pop_desc.x_hi : pop_desc.x_lo;
         second_y      <= corner_b[1] ? pop_desc.y_hi : pop_desc.y_lo;
         second_z      <= corner_b[0] ? pop_desc.z_hi : pop_desc.z_lo;
         last_of_voxel <= voxel_done;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* rtl/tet_voxel_edge_emitter.sv */
// ----------------------------------------------------------------------------
// tet_voxel_edge_emitter: six-tetrahedron marching case expansion
// A voxel passes the intake register, the descriptor queue and the output
// register before its first vertex appears. The sequencer emits one vertex
// item per cycle while rsp_ready allows; a voxel has 0 to 36 vertices. Voxels
// are accepted 1 per cycle while the queue has room; uniform ones are dropped.
// Reset clears the queue, the cursor and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module tet_voxel_edge_emitter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_corner_negative,
   input  logic [31:0] req_x_lo,
   input  logic [31:0] req_x_hi,
   input  logic [31:0] req_y_lo,
   input  logic [31:0] req_y_hi,
   input  logic [31:0] req_z_lo,
   input  logic [31:0] req_z_hi,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_tet_number,
   output logic [2:0]  rsp_vertex_slot,
   output logic [2:0]  rsp_corner_first,
   output logic [2:0]  rsp_corner_second,
   output logic [31:0] rsp_first_x,
   output logic [31:0] rsp_first_y,
   output logic [31:0] rsp_first_z,
   output logic [31:0] rsp_second_x,
   output logic [31:0] rsp_second_y,
   output logic [31:0] rsp_second_z,
   output logic        rsp_last_of_voxel
);

   logic                    push_valid, push_ready;
   tve_pkg::voxel_desc_type push_desc;
   logic                    pop_valid, pop_ready;
   tve_pkg::voxel_desc_type pop_desc;

   // Intake and classification
   tve_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .corner_negative (req_corner_negative),
      .x_lo            (req_x_lo),
      .x_hi            (req_x_hi),
      .y_lo            (req_y_lo),
      .y_hi            (req_y_hi),
      .z_lo            (req_z_lo),
      .z_hi            (req_z_hi),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_desc       (push_desc)
   );

   // Descriptor queue
   tve_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   // Vertex sequencing and output register
   tve_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_desc      (pop_desc),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .tet_number    (rsp_tet_number),
      .vertex_slot   (rsp_vertex_slot),
      .corner_first  (rsp_corner_first),
      .corner_second (rsp_corner_second),
      .first_x       (rsp_first_x),
      .first_y       (rsp_first_y),
      .first_z       (rsp_first_z),
      .second_x      (rsp_second_x),
      .second_y      (rsp_second_y),
      .second_z      (rsp_second_z),
      .last_of_voxel (rsp_last_of_voxel)
   );

   // A voxel's vertices come without gaps until its last one
   a_voxel_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_voxel) |=> rsp_valid)
      else $error("vertex stream of a voxel broke before its last item");

   // Tet and slot stay in range
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tet_number <= 3'd5) && (rsp_vertex_slot <= 3'd5))
      else $error("tet number or vertex slot out of range");

   // A crossed edge joins two distinct corners
   a_edge_distinct : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_corner_first != rsp_corner_second))
      else $error("emitted edge has equal end corners");

   // Within a voxel the tet number never goes backward
   a_tet_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_voxel) |=>
         (rsp_tet_number >= $past(rsp_tet_number)))
      else $error("tet order reversed within a voxel");

endmodule

/* verif/tet_voxel_edge_emitter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tet_voxel_edge_emitter_test: self-checking bench for the voxel edge emitter
// Drives voxels through the request channel with random gaps, stalls the
// vertex channel at random, and checks every vertex item against a predictor
// that expands the six tetrahedra of each accepted voxel in order.
// ----------------------------------------------------------------------------
module tet_voxel_edge_emitter_test;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_VOXELS = 280;

   // Corner loop around the main diagonal; tet t uses entries t and t+1
   localparam tve_pkg::corner_type TET_LOOP [7] =
      '{3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};

   // Triangles per tetrahedron sign case
   localparam int TRIS_PER_CASE [16] = '{0, 1, 1, 2, 1, 2, 2, 1, 1, 2, 2, 1, 2, 1, 1, 0};

   // Crossed edge per case and vertex slot: bits [5:4] start, [1:0] end (tet corners)
   localparam logic [7:0] EDGE_PAIRS [16][6] = '{
      '{'h00, 'h00, 'h00, 'h00, 'h00, 'h00},
      '{'h02, 'h01, 'h03, 'h00, 'h00, 'h00},
      '{'h12, 'h13, 'h10, 'h00, 'h00, 'h00},
      '{'h12, 'h13, 'h03, 'h03, 'h02, 'h12},
      '{'h20, 'h23, 'h21, 'h00, 'h00, 'h00},
      '{'h03, 'h23, 'h21, 'h21, 'h01, 'h03},
      '{'h20, 'h23, 'h10, 'h23, 'h13, 'h10},
      '{'h23, 'h13, 'h03, 'h00, 'h00, 'h00},
      '{'h30, 'h31, 'h32, 'h00, 'h00, 'h00},
      '{'h32, 'h02, 'h01, 'h31, 'h32, 'h01},
      '{'h12, 'h32, 'h30, 'h30, 'h10, 'h12},
      '{'h12, 'h32, 'h02, 'h00, 'h00, 'h00},
      '{'h30, 'h31, 'h21, 'h21, 'h20, 'h30},
      '{'h31, 'h21, 'h01, 'h00, 'h00, 'h00},
      '{'h30, 'h10, 'h20, 'h00, 'h00, 'h00},
      '{'h00, 'h00, 'h00, 'h00, 'h00, 'h00}
   };

   typedef struct packed {
      logic [7:0]  corner_negative;
      logic [31:0] x_lo;
      logic [31:0] x_hi;
      logic [31:0] y_lo;
      logic [31:0] y_hi;
      logic [31:0] z_lo;
      logic [31:0] z_hi;
   } voxel_type;

   typedef struct packed {
      logic [2:0]          tet_number;
      logic [2:0]          vertex_slot;
      tve_pkg::corner_type corner_first;
      tve_pkg::corner_type corner_second;
      logic [31:0]         first_x;
      logic [31:0]         first_y;
      logic [31:0]         first_z;
      logic [31:0]         second_x;
      logic [31:0]         second_y;
      logic [31:0]         second_z;
      logic                last_of_voxel;
   } vertex_type;

   // Expands accepted voxels into expected vertex items and checks the output
   class vertex_scoreboard;
      vertex_type expected_q[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_voxel(voxel_type v);
         tve_pkg::corner_type tc [4];
         logic [3:0] cs;
         logic [7:0] pair;
         tve_pkg::corner_type a;
         tve_pkg::corner_type b;
         vertex_type vx;
         vertex_type batch[$];
         for (int t = 0; t < 6; t++) begin
            tc[0] = 3'd0;
            tc[1] = 3'd7;
            tc[2] = TET_LOOP[t];
            tc[3] = TET_LOOP[t + 1];
            for (int k = 0; k < 4; k++)
               cs[k] = v.corner_negative[tc[k]];
            for (int s = 0; s < 3 * TRIS_PER_CASE[cs]; s++) begin
               pair = EDGE_PAIRS[cs][s];
               a = tc[pair[5:4]];
               b = tc[pair[1:0]];
               vx.tet_number    = 3'(t);
               vx.vertex_slot   = 3'(s);
               vx.corner_first  = a;
               vx.corner_second = b;
               vx.first_x       = a[2] ? v.x_hi : v.x_lo;
               vx.first_y       = a[1] ? v.y_hi : v.y_lo;
               vx.first_z       = a[0] ? v.z_hi : v.z_lo;
               vx.second_x      = b[2] ? v.x_hi : v.x_lo;
               vx.second_y      = b[1] ? v.y_hi : v.y_lo;
               vx.second_z      = b[0] ? v.z_hi : v.z_lo;
               vx.last_of_voxel = 1'b0;
               batch.insert(batch.size(), vx);
            end
         end
         // Mark the final vertex of the voxel
         if (batch.size() > 0) begin
            vx = batch[batch.size() - 1];
            vx.last_of_voxel = 1'b1;
            batch[batch.size() - 1] = vx;
         end
         foreach (batch[i])
            expected_q.insert(expected_q.size(), batch[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         if (expected_q.size() == 0) begin
            $error("vertex item with none expected: tet %0d slot %0d",
                   got.tet_number, got.vertex_slot);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("tet_number", 32'(want.tet_number), 32'(got.tet_number));
         compare_field("vertex_slot", 32'(want.vertex_slot), 32'(got.vertex_slot));
         compare_field("corner_first", 32'(want.corner_first), 32'(got.corner_first));
         compare_field("corner_second", 32'(want.corner_second), 32'(got.corner_second));
         compare_field("first_x", want.first_x, got.first_x);
         compare_field("first_y", want.first_y, got.first_y);
         compare_field("first_z", want.first_z, got.first_z);
         compare_field("second_x", want.second_x, got.second_x);
         compare_field("second_y", want.second_y, got.second_y);
         compare_field("second_z", want.second_z, got.second_z);
         compare_field("last_of_voxel", 32'(want.last_of_voxel), 32'(got.last_of_voxel));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_corner_negative;
   logic [31:0] req_x_lo;
   logic [31:0] req_x_hi;
   logic [31:0] req_y_lo;
   logic [31:0] req_y_hi;
   logic [31:0] req_z_lo;
   logic [31:0] req_z_hi;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_tet_number;
   logic [2:0]  rsp_vertex_slot;
   logic [2:0]  rsp_corner_first;
   logic [2:0]  rsp_corner_second;
   logic [31:0] rsp_first_x;
   logic [31:0] rsp_first_y;
   logic [31:0] rsp_first_z;
   logic [31:0] rsp_second_x;
   logic [31:0] rsp_second_y;
   logic [31:0] rsp_second_z;
   logic        rsp_last_of_voxel;

   vertex_scoreboard vertex_board;
   int idle_cycles;

   tet_voxel_edge_emitter uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_corner_negative(req_corner_negative),
      .req_x_lo          (req_x_lo),
      .req_x_hi          (req_x_hi),
      .req_y_lo          (req_y_lo),
      .req_y_hi          (req_y_hi),
      .req_z_lo          (req_z_lo),
      .req_z_hi          (req_z_hi),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tet_number    (rsp_tet_number),
      .rsp_vertex_slot   (rsp_vertex_slot),
      .rsp_corner_first  (rsp_corner_first),
      .rsp_corner_second (rsp_corner_second),
      .rsp_first_x       (rsp_first_x),
      .rsp_first_y       (rsp_first_y),
      .rsp_first_z       (rsp_first_z),
      .rsp_second_x      (rsp_second_x),
      .rsp_second_y      (rsp_second_y),
      .rsp_second_z      (rsp_second_z),
      .rsp_last_of_voxel (rsp_last_of_voxel)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Coordinate word with the extremes mixed in
   function automatic logic [31:0] random_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 32'h0000_0000;
      if (r == 1)
         return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   function automatic voxel_type make_voxel(logic [7:0] neg, logic [31:0] xl, logic [31:0] xh,
                                            logic [31:0] yl, logic [31:0] yh,
                                            logic [31:0] zl, logic [31:0] zh);
      voxel_type v;
      v.corner_negative = neg;
      v.x_lo = xl;
      v.x_hi = xh;
      v.y_lo = yl;
      v.y_hi = yh;
      v.z_lo = zl;
      v.z_hi = zh;
      return v;
   endfunction

   function automatic voxel_type random_voxel(logic [7:0] neg);
      return make_voxel(neg, random_word(), random_word(), random_word(),
                        random_word(), random_word(), random_word());
   endfunction

   // Present one voxel and hold it until accepted
   task automatic send_voxel(voxel_type v);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_corner_negative <= v.corner_negative;
      req_x_lo            <= v.x_lo;
      req_x_hi            <= v.x_hi;
      req_y_lo            <= v.y_lo;
      req_y_hi            <= v.y_hi;
      req_z_lo            <= v.z_lo;
      req_z_hi            <= v.z_hi;
      do
         @(posedge clock);
      while (!req_ready);
      vertex_board.note_voxel(v);
   endtask

   // Drop valid for the given number of cycles
   task automatic idle_req(int cycles);
      if (cycles == 0)
         return;
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop valid and wait until every expected vertex has come out
   task automatic drain_req();
      @(negedge clock);
      req_valid <= 1'b0;
      while (vertex_board.pending() != 0)
         @(posedge clock);
   endtask

   // Toggle the vertex channel ready: runs of acceptance with random stalls
   initial begin : rsp_stall_gen
      int run;
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         run = $urandom_range(1, 30);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         hold = gap_length();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
      end
   end

   // Check each accepted vertex item
   always @(posedge clock) begin : rsp_monitor
      vertex_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.tet_number    = rsp_tet_number;
         got.vertex_slot   = rsp_vertex_slot;
         got.corner_first  = rsp_corner_first;
         got.corner_second = rsp_corner_second;
         got.first_x       = rsp_first_x;
         got.first_y       = rsp_first_y;
         got.first_z       = rsp_first_z;
         got.second_x      = rsp_second_x;
         got.second_y      = rsp_second_y;
         got.second_z      = rsp_second_z;
         got.last_of_voxel = rsp_last_of_voxel;
         vertex_board.check_vertex(got);
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      voxel_type v;
      int sent;
      logic [7:0] neg;
      vertex_board        = new();
      idle_cycles         = 0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_corner_negative = 8'h00;
      req_x_lo            = 32'h0;
      req_x_hi            = 32'h0;
      req_y_lo            = 32'h0;
      req_y_hi            = 32'h0;
      req_z_lo            = 32'h0;
      req_z_hi            = 32'h0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Uniform voxels emit nothing
      send_voxel(make_voxel(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_voxel(make_voxel(8'hFF, '1, '1, '1, '1, '1, '1));
      // Every tet split in two: the full 36 vertices
      send_voxel(make_voxel(8'h69, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1111_1111,
                            32'hEEEE_EEEE, 32'h2222_2222, 32'hDDDD_DDDD));
      send_voxel(make_voxel(8'h96, 32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF));
      // One corner negative, then one corner positive
      for (int c = 0; c < 8; c++)
         send_voxel(random_voxel(8'(1 << c)));
      for (int c = 0; c < 8; c++)
         send_voxel(random_voxel(~8'(1 << c)));
      // Half-cube splits
      send_voxel(make_voxel(8'h0F, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000));
      send_voxel(make_voxel(8'hF0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'h8000_0000, 32'h0000_0001));
      drain_req();

      // Random voxels with random gaps; drain now and then
      sent = 0;
      while (sent < RANDOM_VOXELS) begin
         idle_req(gap_length());
         neg = 8'($urandom_range(0, 255));
         send_voxel(random_voxel(neg));
         if (neg != 8'h00 && neg != 8'hFF)
            sent++;
         if (sent % 90 == 89)
            drain_req();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Let the last vertices out, then a few quiet cycles
      while (vertex_board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (vertex_board.failures == 0 && vertex_board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
